@@ design/ssl_pkg.sv @@
// Shared types and constants for the S-record stream loader.
// No dependencies; used by srecord_stream_loader_core.
package ssl_pkg;

    // Position of the parser within one text line
    typedef enum logic [2:0] {
        PH_START,
        PH_TYPE,
        PH_LEN,
        PH_ADDR,
        PH_DATA,
        PH_IGNORE
    } phase_t;

    // Result kinds carried on m_tuser
    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Characters the parser looks for
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Addresses above this drop the rest of their record
    localparam logic [31:0] HIGH_SECTION_LIMIT = 32'h0080_0000;
    // Target memory size after reset
    localparam logic [31:0] BUFFER_SIZE_RESET  = 32'h0001_0000;
    localparam logic [31:0] ALL_ONES           = 32'hFFFF_FFFF;

    // Width of the packed result payload on m_tdata
    localparam int OUT_DATA_W = 144;

endpackage

@@ design/srecord_stream_loader_core.sv @@
// S-record stream loader: parses S-record text one character per beat and
// emits memory writes and an end-of-load summary. Depends on ssl_pkg.
//
// A result is registered and appears on the master side in the cycle after the input beat.
// Throughput: one input beat per cycle; the output register lets a new beat
// in whenever the held result is taken in the same cycle or none is held.
// Reset (rst_n low, asynchronous): parser at start of line, statistics
// cleared, buffer_size back to 65536, output register empty.
module srecord_stream_loader_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration: buffer_size
    input  logic                           cfg_we,
    input  logic [31:0]                    cfg_wdata,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] ch
    input  logic                           s_tuser,  // [0] end_of_file
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] write_address, [39:32] write_data, [71:40] first_address,
    // [103:72] last_address, [135:104] byte_count, [136] overflow_error,
    // [143:137] zero
    output logic [ssl_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser   // [0] out_kind
);

    // Parser state
    ssl_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  lcc_reg, lcc_next;        // line char count, saturates at 3
    logic [1:0]  kind_reg, kind_next;      // data record type 1..3
    logic [7:0]  len_reg, len_next;
    logic [2:0]  dc_reg, dc_next;          // hex digit counter
    logic [31:0] addr_reg, addr_next;      // address of the next data byte
    logic [7:0]  left_reg, left_next;      // data bytes still to come
    logic [3:0]  hi_reg, hi_next;
    logic [31:0] lowest_reg, lowest_next;
    logic [31:0] highest_reg, highest_next;
    logic [31:0] count_reg, count_next;
    logic        stopped_reg, stopped_next;
    logic        aborted_reg, aborted_next;
    logic [31:0] bufsize_reg;

    // Output register
    logic        m_valid_reg;
    logic        m_kind_reg;
    logic [31:0] wa_reg, fa_reg, la_reg, bc_reg;
    logic [7:0]  wd_reg;
    logic        ov_reg;

    // Result of the current beat
    logic        res_fire;
    logic        res_kind;
    logic [31:0] res_wa, res_fa, res_la, res_bc;
    logic [7:0]  res_wd;
    logic        res_ov;

    logic        s_fire;
    logic        is_digit;
    logic [3:0]  hex_val;
    logic [7:0]  overhead;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // Decode one hex digit, anything else reads as zero
    always_comb
    begin
        is_digit = (s_tdata >= ssl_pkg::CH_0) && (s_tdata <= ssl_pkg::CH_9);
        if (is_digit)
            hex_val = 4'(s_tdata - ssl_pkg::CH_0);
        else if ((s_tdata >= ssl_pkg::CH_UA) && (s_tdata <= ssl_pkg::CH_UF))
            hex_val = 4'(s_tdata - ssl_pkg::CH_UA + 8'd10);
        else if ((s_tdata >= ssl_pkg::CH_LA) && (s_tdata <= ssl_pkg::CH_LF_HEX))
            hex_val = 4'(s_tdata - ssl_pkg::CH_LA + 8'd10);
        else
            hex_val = 4'd0;
    end

    assign overhead = {6'd0, kind_reg} + 8'd2;

    // Advance the parser and form the result of an accepted beat
    always_comb
    begin
        phase_next   = phase_reg;
        lcc_next     = lcc_reg;
        kind_next    = kind_reg;
        len_next     = len_reg;
        dc_next      = dc_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        hi_next      = hi_reg;
        lowest_next  = lowest_reg;
        highest_next = highest_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        aborted_next = aborted_reg;

        res_fire = 1'b0;
        res_kind = ssl_pkg::KIND_WRITE;
        res_wa   = '0;
        res_wd   = '0;
        res_fa   = '0;
        res_la   = '0;
        res_bc   = '0;
        res_ov   = 1'b0;

        if (s_fire)
        begin
            if (s_tuser)
            begin
                // Report the summary and start a new load
                res_fire = 1'b1;
                res_kind = ssl_pkg::KIND_SUMMARY;
                res_fa   = aborted_reg ? ssl_pkg::ALL_ONES : lowest_reg;
                res_la   = aborted_reg ? 32'd0 : highest_reg;
                res_bc   = aborted_reg ? 32'd0 : count_reg;
                res_ov   = aborted_reg;
                phase_next   = ssl_pkg::PH_START;
                lcc_next     = '0;
                kind_next    = '0;
                len_next     = '0;
                dc_next      = '0;
                addr_next    = '0;
                left_next    = '0;
                hi_next      = '0;
                lowest_next  = ssl_pkg::ALL_ONES;
                highest_next = '0;
                count_next   = '0;
                stopped_next = 1'b0;
                aborted_next = 1'b0;
            end
            else if (!stopped_reg && !aborted_reg)
            begin
                if ((s_tdata == ssl_pkg::CH_CR) || (s_tdata == ssl_pkg::CH_LF))
                begin
                    // End of line: skip empty lines, stop on very short ones
                    if (lcc_reg != 2'd0)
                    begin
                        if (lcc_reg != 2'd3)
                            stopped_next = 1'b1;
                        phase_next = ssl_pkg::PH_START;
                        lcc_next   = '0;
                        kind_next  = '0;
                        len_next   = '0;
                        dc_next    = '0;
                        addr_next  = '0;
                        left_next  = '0;
                        hi_next    = '0;
                    end
                end
                else
                begin
                    if (lcc_reg != 2'd3)
                        lcc_next = lcc_reg + 2'd1;
                    unique case (phase_reg)
                        ssl_pkg::PH_START:
                        begin
                            phase_next = (s_tdata == ssl_pkg::CH_S) ? ssl_pkg::PH_TYPE
                                                                    : ssl_pkg::PH_IGNORE;
                        end
                        ssl_pkg::PH_TYPE:
                        begin
                            len_next = '0;
                            dc_next  = '0;
                            if (is_digit && (hex_val >= 4'd1) && (hex_val <= 4'd3))
                            begin
                                kind_next  = hex_val[1:0];
                                phase_next = ssl_pkg::PH_LEN;
                            end
                            else
                            begin
                                phase_next = ssl_pkg::PH_IGNORE;
                            end
                        end
                        ssl_pkg::PH_LEN:
                        begin
                            len_next = {len_reg[3:0], hex_val};
                            if (dc_reg[0])
                            begin
                                dc_next    = '0;
                                addr_next  = '0;
                                phase_next = ssl_pkg::PH_ADDR;
                            end
                            else
                            begin
                                dc_next = dc_reg + 3'd1;
                            end
                        end
                        ssl_pkg::PH_ADDR:
                        begin
                            addr_next = {addr_reg[27:0], hex_val};
                            if (dc_reg == {kind_reg, 1'b1})
                            begin
                                dc_next   = '0;
                                left_next = len_reg - overhead;
                                phase_next = (len_reg > overhead) ? ssl_pkg::PH_DATA
                                                                  : ssl_pkg::PH_IGNORE;
                            end
                            else
                            begin
                                dc_next = dc_reg + 3'd1;
                            end
                        end
                        ssl_pkg::PH_DATA:
                        begin
                            if (dc_reg == 3'd0)
                            begin
                                hi_next = hex_val;
                                dc_next = 3'd1;
                            end
                            else
                            begin
                                // Second digit completes a byte
                                dc_next   = '0;
                                addr_next = addr_reg + 32'd1;
                                left_next = left_reg - 8'd1;
                                if (left_reg == 8'd1)
                                    phase_next = ssl_pkg::PH_IGNORE;
                                if (addr_reg < lowest_reg)
                                    lowest_next = addr_reg;
                                if (addr_reg > ssl_pkg::HIGH_SECTION_LIMIT)
                                begin
                                    phase_next = ssl_pkg::PH_IGNORE;
                                end
                                else if (addr_reg >= bufsize_reg)
                                begin
                                    aborted_next = 1'b1;
                                end
                                else
                                begin
                                    if (count_reg != ssl_pkg::ALL_ONES)
                                        count_next = count_reg + 32'd1;
                                    if (addr_reg > highest_reg)
                                        highest_next = addr_reg;
                                    res_fire = 1'b1;
                                    res_wa   = addr_reg;
                                    res_wd   = {hi_reg, hex_val};
                                end
                            end
                        end
                        ssl_pkg::PH_IGNORE:
                        begin
                            phase_next = ssl_pkg::PH_IGNORE;
                        end
                        default:
                        begin
                            phase_next = ssl_pkg::PH_IGNORE;
                        end
                    endcase
                end
            end
        end
    end

    // Parser and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ssl_pkg::PH_START;
            lcc_reg     <= '0;
            kind_reg    <= '0;
            len_reg     <= '0;
            dc_reg      <= '0;
            addr_reg    <= '0;
            left_reg    <= '0;
            hi_reg      <= '0;
            lowest_reg  <= ssl_pkg::ALL_ONES;
            highest_reg <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            aborted_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            lcc_reg     <= lcc_next;
            kind_reg    <= kind_next;
            len_reg     <= len_next;
            dc_reg      <= dc_next;
            addr_reg    <= addr_next;
            left_reg    <= left_next;
            hi_reg      <= hi_next;
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
            aborted_reg <= aborted_next;
        end
    end

    // Buffer size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bufsize_reg <= ssl_pkg::BUFFER_SIZE_RESET;
        else if (cfg_we)
            bufsize_reg <= cfg_wdata;
    end

    // Hold the result until the master side takes the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (res_fire)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            m_kind_reg <= res_kind;
            wa_reg     <= res_wa;
            wd_reg     <= res_wd;
            fa_reg     <= res_fa;
            la_reg     <= res_la;
            bc_reg     <= res_bc;
            ov_reg     <= res_ov;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {7'd0, ov_reg, bc_reg, la_reg, fa_reg, wd_reg, wa_reg};

endmodule
